>>> sv/kbd_pkg.sv
// Shared types and constants for the keyed box downsampler.
package kbd_pkg;
    localparam int SUM_W = 14;
    localparam int CNT_W = 7;
    localparam int CH_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_R   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_G   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B   = 3'd4;

    typedef struct packed {
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [SUM_W-1:0] sum_a;
        logic [CNT_W-1:0] count;
    } t_acc;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // accept a pixel: latch and start memory read
        logic accum;  // apply the read entry, write back
        logic div;    // advance the divider one step
        logic emit;   // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_cell;
        logic last_px;
        logic div_done;
    } t_stat;
endpackage

>>> sv/kbd_if.sv
// Valid/ready channel interface carrying a payload.
interface kbd_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/kbd_ctrl.sv
// Controller state machine for the keyed box downsampler.
module kbd_ctrl import kbd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                if (i_stat.in_cell && i_stat.last_px) n_state = S_DIV;
                else n_state = S_IDLE;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_out_busy) else $error("emit while output full");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_ACC) else $error("load did not go to accumulate");
    a_div_from: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ($past(r_state) == S_ACC || $past(r_state) == S_DIV))
        else $error("divide entered from wrong state");
endmodule

>>> sv/kbd_datapath.sv
// Datapath: position counters, column accumulator memory and serial divider.
module kbd_datapath import kbd_pkg::*; #(
    parameter int TILE_W = 64,
    parameter int TILE_H = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [CH_W-1:0]   i_red,
    input  logic [CH_W-1:0]   i_green,
    input  logic [CH_W-1:0]   i_blue,
    input  logic [CH_W-1:0]   i_alpha,
    input  logic              i_tile_start,
    input  logic [1:0]        i_scale_x,
    input  logic [1:0]        i_scale_y,
    input  logic [CH_W-1:0]   i_key_r,
    input  logic [CH_W-1:0]   i_key_g,
    input  logic [CH_W-1:0]   i_key_b,
    output logic [CH_W-1:0]   o_r,
    output logic [CH_W-1:0]   o_g,
    output logic [CH_W-1:0]   o_b,
    output logic [CH_W-1:0]   o_a,
    output logic              o_done
);
    localparam int CW = $clog2(TILE_W);
    localparam int RW = $clog2(TILE_H);
    localparam int QW = SUM_W;

    t_acc r_mem [TILE_W];
    t_acc r_rd;
    logic [CW-1:0] r_col, n_col, r_cx;
    logic [RW-1:0] r_row, n_row;
    logic [CH_W-1:0] r_px_r, r_px_g, r_px_b, r_px_a;
    logic r_first, r_last, r_in, r_tdone;
    logic [CW-1:0] col_now;
    logic [RW-1:0] row_now;
    logic [CW:0] cells_x, cx_w;
    logic [RW:0] cells_y, cy_w;
    logic [CW-1:0] tx;
    logic [RW-1:0] ty;
    logic keyed;
    t_acc upd;

    // Divider: four channels share one restoring step per cycle.
    logic [QW-1:0] r_num [4];
    logic [CNT_W-1:0] r_rem [4];
    logic [CNT_W-1:0] r_den;
    logic [3:0] r_step;
    logic r_empty;

    always_comb begin
        col_now = i_tile_start ? '0 : r_col;
        row_now = i_tile_start ? '0 : r_row;
        cells_x = (CW+1)'(TILE_W) >> i_scale_x;
        cells_y = (RW+1)'(TILE_H) >> i_scale_y;
        cx_w = {1'b0, col_now} >> i_scale_x;
        cy_w = {1'b0, row_now} >> i_scale_y;
        tx = col_now & CW'((1 << i_scale_x) - 1);
        ty = row_now & RW'((1 << i_scale_y) - 1);
        if (col_now == CW'(TILE_W - 1)) begin
            n_col = '0;
            n_row = (row_now == RW'(TILE_H - 1)) ? '0 : row_now + 1'b1;
        end else begin
            n_col = col_now + 1'b1;
            n_row = row_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px_r <= i_red;
            r_px_g <= i_green;
            r_px_b <= i_blue;
            r_px_a <= i_alpha;
            r_cx <= cx_w[CW-1:0];
            r_in <= (cx_w < cells_x) && (cy_w < cells_y);
            r_first <= (tx == '0) && (ty == '0);
            r_last <= (tx == CW'((1 << i_scale_x) - 1)) && (ty == RW'((1 << i_scale_y) - 1));
            r_tdone <= (cx_w == cells_x - 1'b1) && (cy_w == cells_y - 1'b1);
            r_rd <= r_mem[cx_w[CW-1:0]];
        end
    end

    always_comb begin
        keyed = (r_px_r == i_key_r) && (r_px_g == i_key_g) && (r_px_b == i_key_b);
        upd = r_first ? '0 : r_rd;
        if (!keyed) begin
            upd.sum_r = upd.sum_r + SUM_W'(r_px_r);
            upd.sum_g = upd.sum_g + SUM_W'(r_px_g);
            upd.sum_b = upd.sum_b + SUM_W'(r_px_b);
            upd.sum_a = upd.sum_a + SUM_W'(r_px_a);
            upd.count = upd.count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && r_in) r_mem[r_cx] <= upd;
    end

    always_comb begin
        o_stat.in_cell = r_in;
        o_stat.last_px = r_last;
        o_stat.div_done = (r_step == 4'(QW - 1));
    end

    // Restoring division: one quotient bit per channel per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum) begin
            r_num[0] <= upd.sum_r;
            r_num[1] <= upd.sum_g;
            r_num[2] <= upd.sum_b;
            r_num[3] <= upd.sum_a;
            for (int k = 0; k < 4; k++) r_rem[k] <= '0;
            r_den <= upd.count;
            r_empty <= (upd.count == '0);
            r_step <= '0;
        end else if (i_cmd.div) begin
            for (int k = 0; k < 4; k++) begin
                logic [CNT_W:0] t;
                t = {r_rem[k], r_num[k][QW-1]};
                if (t >= {1'b0, r_den}) begin
                    t = t - {1'b0, r_den};
                    r_num[k] <= {r_num[k][QW-2:0], 1'b1};
                end else begin
                    r_num[k] <= {r_num[k][QW-2:0], 1'b0};
                end
                r_rem[k] <= t[CNT_W-1:0];
            end
            r_step <= r_step + 1'b1;
        end
    end

    always_comb begin
        o_r = r_empty ? i_key_r : r_num[0][CH_W-1:0];
        o_g = r_empty ? i_key_g : r_num[1][CH_W-1:0];
        o_b = r_empty ? i_key_b : r_num[2][CH_W-1:0];
        o_a = r_empty ? '0 : r_num[3][CH_W-1:0];
        o_done = r_tdone;
    end
endmodule

>>> sv/keyed_box_downsampler.sv
// Top level: keyed box downsampler with config registers and output register.
// A pixel that closes a cell goes through accumulate, the 14-step serial divider and emit;
// emit waits while the output register is full. The next pixel is accepted only once
// the controller is back in idle, after the previous pixel has been fully handled.
// Reset (synchronous, active low) clears position, registers and output valid.
// The column accumulator memory needs no clearing; each cell starts fresh.
module keyed_box_downsampler import kbd_pkg::*; #(
    parameter int TILE_W = 64,
    parameter int TILE_H = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kbd_if.sink                   s_in,
    kbd_if.source                 m_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [1:0] r_sx, r_sy;
    logic [CH_W-1:0] r_kr, r_kg, r_kb;
    logic r_ovalid;
    logic [4*CH_W:0] r_odata;
    t_cmd cmd;
    t_stat stat;
    logic [CH_W-1:0] dr, dg, db, da;
    logic dd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0; r_sy <= '0;
            r_kr <= 8'd0; r_kg <= 8'd255; r_kb <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCALE_X: r_sx <= i_cfg_data[1:0];
                REG_SCALE_Y: r_sy <= i_cfg_data[1:0];
                REG_KEY_R:   r_kr <= i_cfg_data;
                REG_KEY_G:   r_kg <= i_cfg_data;
                REG_KEY_B:   r_kb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kbd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_in.valid),
        .o_in_ready(s_in.ready), .i_out_busy(r_ovalid && !m_out.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    kbd_datapath #(.TILE_W(TILE_W), .TILE_H(TILE_H)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_red(s_in.data[7:0]), .i_green(s_in.data[15:8]),
        .i_blue(s_in.data[23:16]), .i_alpha(s_in.data[31:24]),
        .i_tile_start(s_in.data[32]),
        .i_scale_x(r_sx), .i_scale_y(r_sy),
        .i_key_r(r_kr), .i_key_g(r_kg), .i_key_b(r_kb),
        .o_r(dr), .o_g(dg), .o_b(db), .o_a(da), .o_done(dd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (cmd.emit) r_ovalid <= 1'b1;
        else if (m_out.ready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) r_odata <= {dd, da, db, dg, dr};
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data = r_odata;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_out.ready) |=> $stable(r_odata)) else $error("output overwritten");
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> r_ovalid) else $error("emit lost");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready |-> !cmd.div) else $error("accepting while dividing");
endmodule

>>> tb/tb.sv
// Self-checking testbench for the keyed box downsampler.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kbd_pkg::*;

    localparam int TILE_W = 64;
    localparam int TILE_H = 64;
    localparam int PX_W = 4 * CH_W + 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            flag;
    } t_pixel;

    // Predicts downsampled cells and checks each transaction on the output channel.
    class cell_scoreboard;
        t_pixel          pending[$];
        t_acc            col_acc[TILE_W];
        int unsigned     src_col;
        int unsigned     src_row;
        logic [1:0]      shift_x;
        logic [1:0]      shift_y;
        logic [CH_W-1:0] key[3];
        int              errors;

        function void reset_state();
            foreach (col_acc[i]) col_acc[i] = '0;
            src_col = 0;
            src_row = 0;
            shift_x = '0;
            shift_y = '0;
            key[0] = 8'd0;
            key[1] = 8'd255;
            key[2] = 8'd0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SCALE_X: shift_x = val[1:0];
                REG_SCALE_Y: shift_y = val[1:0];
                REG_KEY_R:   key[0] = val;
                REG_KEY_G:   key[1] = val;
                REG_KEY_B:   key[2] = val;
                default: ;
            endcase
        endfunction

        function void note_pixel(t_pixel px);
            int unsigned cx, cy, tx, ty, nx, ny;
            t_pixel res;
            logic keyed;
            if (px.flag) begin
                src_col = 0;
                src_row = 0;
            end
            nx = TILE_W >> shift_x;
            ny = TILE_H >> shift_y;
            cx = src_col >> shift_x;
            cy = src_row >> shift_y;
            tx = src_col & ((1 << shift_x) - 1);
            ty = src_row & ((1 << shift_y) - 1);
            if (cx < nx && cy < ny) begin
                keyed = px.red == key[0] && px.green == key[1] && px.blue == key[2];
                if (tx == 0 && ty == 0) col_acc[cx] = '0;
                if (!keyed) begin
                    col_acc[cx].sum_r += px.red;
                    col_acc[cx].sum_g += px.green;
                    col_acc[cx].sum_b += px.blue;
                    col_acc[cx].sum_a += px.alpha;
                    col_acc[cx].count += 1;
                end
                if (tx == (1 << shift_x) - 1 && ty == (1 << shift_y) - 1) begin
                    if (col_acc[cx].count != 0) begin
                        res.red   = 8'(col_acc[cx].sum_r / col_acc[cx].count);
                        res.green = 8'(col_acc[cx].sum_g / col_acc[cx].count);
                        res.blue  = 8'(col_acc[cx].sum_b / col_acc[cx].count);
                        res.alpha = 8'(col_acc[cx].sum_a / col_acc[cx].count);
                    end else begin
                        res.red   = key[0];
                        res.green = key[1];
                        res.blue  = key[2];
                        res.alpha = 8'd0;
                    end
                    res.flag = (cx == nx - 1 && cy == ny - 1);
                    pending.push_back(res);
                end
            end
            src_col++;
            if (src_col >= TILE_W) begin
                src_col = 0;
                src_row = (src_row + 1 >= TILE_H) ? 0 : src_row + 1;
            end
        endfunction

        function void check_result(t_pixel got);
            t_pixel want;
            if (pending.size() == 0) begin
                $error("unexpected output transaction %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red) begin
                $error("out_red: expected %0d, got %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $error("out_green: expected %0d, got %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
                errors++;
            end
            if (got.alpha !== want.alpha) begin
                $error("out_alpha: expected %0d, got %0d", want.alpha, got.alpha);
                errors++;
            end
            if (got.flag !== want.flag) begin
                $error("tile_done: expected %0d, got %0d", want.flag, got.flag);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    kbd_if #(.W(PX_W)) pix_in ();
    kbd_if #(.W(PX_W)) cell_out ();

    keyed_box_downsampler #(.TILE_W(TILE_W), .TILE_H(TILE_H)) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_in(pix_in.sink),
        .m_out(cell_out.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    cell_scoreboard sb = new();
    int unsigned cycle = 0;
    int unsigned hold_left = 0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    logic [CH_W-1:0] cur_key[3];

    // The channel carries red in the low byte and the flag in the top bit.
    function automatic logic [PX_W-1:0] to_bus(t_pixel px);
        return {px.flag, px.alpha, px.blue, px.green, px.red};
    endfunction

    function automatic t_pixel from_bus(logic [PX_W-1:0] d);
        t_pixel px;
        px.red   = d[7:0];
        px.green = d[15:8];
        px.blue  = d[23:16];
        px.alpha = d[31:24];
        px.flag  = d[32];
        return px;
    endfunction

    initial begin
        pix_in.valid = 1'b0;
        pix_in.data = '0;
        cell_out.ready = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: check accepted transactions, then choose the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && cell_out.valid && cell_out.ready) sb.check_result(from_bus(cell_out.data));
        if (hold_request && !hold_taken && hold_left == 0) begin
            hold_left = 400;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            cell_out.ready <= 1'b0;
        end else if (cycle > 3000 && cycle < 9000) begin
            cell_out.ready <= 1'b1;
        end else begin
            cell_out.ready <= ($urandom_range(99) >= 18);
        end
    end

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_mode(int sx, int sy, int kr, int kg, int kb);
        write_cfg(REG_SCALE_X, CFG_DATA_W'(sx));
        write_cfg(REG_SCALE_Y, CFG_DATA_W'(sy));
        write_cfg(REG_KEY_R, CFG_DATA_W'(kr));
        write_cfg(REG_KEY_G, CFG_DATA_W'(kg));
        write_cfg(REG_KEY_B, CFG_DATA_W'(kb));
        cur_key[0] = CH_W'(kr);
        cur_key[1] = CH_W'(kg);
        cur_key[2] = CH_W'(kb);
    endtask

    // Offers one pixel; returns after the transaction has been accepted.
    task automatic send_pixel(t_pixel px);
        if ((cycle < 3000 || cycle > 9000) && $urandom_range(99) < 18) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data <= to_bus(px);
        do @(posedge i_clk); while (!pix_in.ready);
        sb.note_pixel(px);
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pixel rand_pixel(int key_pct, bit restart);
        t_pixel px;
        px.red = 8'($urandom);
        px.green = 8'($urandom);
        px.blue = 8'($urandom);
        px.alpha = 8'($urandom);
        if ($urandom_range(99) < key_pct) begin
            px.red = cur_key[0];
            px.green = cur_key[1];
            px.blue = cur_key[2];
        end
        px.flag = restart;
        return px;
    endfunction

    // A phase starts a fresh tile so no column entry is read before it is cleared.
    task automatic run_tile(int count, int key_pct);
        int row_pct;
        row_pct = key_pct;
        for (int n = 0; n < count; n++) begin
            if (n % TILE_W == 0) row_pct = ($urandom_range(9) == 0) ? 100 : key_pct;
            send_pixel(rand_pixel(row_pct, n == 0 || $urandom_range(1999) == 0));
        end
    endtask

    initial begin
        t_pixel px;
        sb.reset_state();
        cur_key[0] = 8'd0;
        cur_key[1] = 8'd255;
        cur_key[2] = 8'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, keyed pixels and empty cells at reset settings, then at scale 1 with a white key.
        px = t_pixel'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
        send_pixel(px);
        px = t_pixel'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
        send_pixel(px);
        px = t_pixel'{8'd0, 8'd255, 8'd0, 8'd200, 1'b0};
        send_pixel(px);
        px = t_pixel'{8'd255, 8'd0, 8'd255, 8'd0, 1'b0};
        send_pixel(px);
        drain();
        set_mode(1, 1, 255, 255, 255);
        for (int n = 0; n < 2 * TILE_W; n++) begin
            px = (n < 8 || n == TILE_W || n == TILE_W + 1)
                ? t_pixel'{8'd255, 8'd255, 8'd255, 8'($urandom), n == 0}
                : t_pixel'{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), n == 0};
            send_pixel(px);
        end
        drain();

        // Random phases across scale and key settings.
        set_mode(0, 0, 0, 0, 0);
        hold_request = 1'b1;
        run_tile(100, 20);
        hold_request = 1'b0;
        drain();
        set_mode(3, 3, 255, 0, 255);
        run_tile(8 * TILE_W + 8, 20);
        drain();
        set_mode(2, 0, 18, 200, 7);
        run_tile(60, 40);
        drain();
        set_mode(1, 2, 128, 128, 128);
        run_tile(4 * TILE_W + 4, 30);
        drain();

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> sim.f
sv/kbd_pkg.sv
sv/kbd_if.sv
sv/kbd_ctrl.sv
sv/kbd_datapath.sv
sv/keyed_box_downsampler.sv
tb/tb.sv
